### rtl/sgdlr_pkg.sv
// ----------------------------------------------------------------------------
// sgdlr_pkg
// Shared widths, codes, command/status types and helpers of the SGD trainer.
// ----------------------------------------------------------------------------
package sgdlr_pkg;

    localparam int WEIGHT_WIDTH = 48;
    localparam int FEATURE_W    = 16;
    localparam int TARGET_W     = 32;
    localparam int COST_W       = 32;
    localparam int OP_W         = 2;
    localparam int SHIFT_W      = 6;
    localparam int INIT_W       = 48;
    localparam int CFG_DATA_W   = 48;
    localparam int CFG_INDEX_W  = 3;
    localparam int ERR_W        = TARGET_W + 1;
    localparam int PROD_W       = WEIGHT_WIDTH + FEATURE_W;
    localparam int SUM_W        = PROD_W + 2;
    localparam int DELTA_W      = PROD_W + 16;
    localparam int SQ_W         = 2 * TARGET_W;

    localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
    localparam logic [OP_W-1:0] OP_TRAIN   = 2'd1;
    localparam logic [OP_W-1:0] OP_PREDICT = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEARN_SHIFT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COST_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIAS_INIT      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_A_INIT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_B_INIT  = 3'd4;

    localparam logic [SHIFT_W-1:0] LEARN_SHIFT_RST    = 6'd27;
    localparam logic [COST_W-1:0]  COST_THRESHOLD_RST = 32'd6554;
    localparam logic [INIT_W-1:0]  BIAS_INIT_RST      = 48'd42949673;
    localparam logic [INIT_W-1:0]  WEIGHT_A_INIT_RST  = 48'd38654706;
    localparam logic [INIT_W-1:0]  WEIGHT_B_INIT_RST  = 48'd128849019;

    typedef enum logic [1:0] {
        MUL_WA_FA,
        MUL_WB_FB,
        MUL_ERR_FA,
        MUL_ERR_FB
    } mul_sel_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_BIAS,
        UPD_WA,
        UPD_WB
    } upd_sel_t;

    typedef struct packed {
        logic     load;
        logic     init;
        mul_sel_t mul_sel;
        logic     cap_pa;
        logic     sum;
        logic     pred;
        logic     pred_first;
        upd_sel_t upd_sel;
        logic     square;
        logic     cost;
        logic     result;
    } dp_cmd_t;

    typedef struct packed {
        logic is_init;
        logic train_go;
    } dp_status_t;

    // Sign extend an init register and clamp it to the weight range.
    function automatic logic [WEIGHT_WIDTH-1:0] sat_init(input logic [INIT_W-1:0] v);
        logic [63:0] ext;
        logic        fits;
        ext  = {{(64-INIT_W){v[INIT_W-1]}}, v};
        fits = (&ext[63:WEIGHT_WIDTH-1]) | ~(|ext[63:WEIGHT_WIDTH-1]);
        if (fits)
            return ext[WEIGHT_WIDTH-1:0];
        else if (ext[63])
            return {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
    endfunction

endpackage

### rtl/sgdlr_if.sv
// ----------------------------------------------------------------------------
// sgdlr_req_if / sgdlr_rsp_if
// Valid/ready channels for trainer requests and results.
// ----------------------------------------------------------------------------
interface sgdlr_req_if;
    import sgdlr_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [OP_W-1:0]             op;
    logic signed [FEATURE_W-1:0] feature_a;
    logic signed [FEATURE_W-1:0] feature_b;
    logic signed [TARGET_W-1:0]  target;

    modport source (output valid, output op, output feature_a, output feature_b,
                    output target, input ready);
    modport sink   (input valid, input op, input feature_a, input feature_b,
                    input target, output ready);
endinterface

interface sgdlr_rsp_if;
    import sgdlr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [TARGET_W-1:0] prediction;
    logic [COST_W-1:0]          cost;
    logic                       converged;

    modport source (output valid, output prediction, output cost, output converged,
                    input ready);
    modport sink   (input valid, input prediction, input cost, input converged,
                    output ready);
endinterface

### rtl/sgd_linear_regression_trainer.sv
// ----------------------------------------------------------------------------
// sgd_linear_regression_trainer
// Online LMS trainer for bias + two-feature linear model, fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Kind          Contents
//  --------  ------------  ----------------------------------------------------
//  req       valid/ready   op, feature_a, feature_b, target (one request)
//  rsp       valid/ready   prediction, cost, converged (one result per request)
//  cfg       write strobe  cfg_write, cfg_index, cfg_data (no read-back)
//
//  One request at a time; the next request is taken in the cycle after the
//  result is loaded. The sequencer steps one shared 48x16 multiplier
//  through predict, three weight updates and a second predict, then the
//  32x32 squarer and the cost clamp; predict (or frozen train) ends after
//  the first predict, and init only loads the initial weights.
//  The result register parts the sides: a waiting result stalls only the
//  final step of the next request. Reset is asynchronous, active low, and
//  restores the register defaults and the default weights.
//
// ----------------------------------------------------------------------------
module sgd_linear_regression_trainer (
    input  logic                              clk,
    input  logic                              rst_n,
    sgdlr_req_if.sink                         req,
    sgdlr_rsp_if.source                       rsp,
    input  logic                              cfg_write,
    input  logic [sgdlr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sgdlr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sgdlr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;
    logic       out_valid;

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

    // Sequence the request: predict pass, optional update and cost pass, result.
    sgdlr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold weights and registers; do the arithmetic each step asks for.
    sgdlr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (req.op),
        .feature_a  (req.feature_a),
        .feature_b  (req.feature_b),
        .target     (req.target),
        .prediction (rsp.prediction),
        .cost       (rsp.cost),
        .converged  (rsp.converged),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

### rtl/sgdlr_ctrl.sv
// ----------------------------------------------------------------------------
// sgdlr_ctrl
// Sequencer: steps the datapath through predict, update and cost passes.
// ----------------------------------------------------------------------------
module sgdlr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  sgdlr_pkg::dp_status_t status,
    output sgdlr_pkg::dp_cmd_t    cmd
);
    import sgdlr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_PRED,
        ST_UPD_BIAS,
        ST_UPD_A,
        ST_UPD_B,
        ST_SQUARE,
        ST_COST,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pass_next  = 1'b0;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                if (!pass_reg && status.is_init)
                begin
                    cmd.init   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.mul_sel = MUL_WA_FA;
                    state_next  = ST_MUL_B;
                end
            end
            ST_MUL_B:
            begin
                cmd.mul_sel = MUL_WB_FB;
                cmd.cap_pa  = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_PRED;
            end
            ST_PRED:
            begin
                cmd.pred       = 1'b1;
                cmd.pred_first = !pass_reg;
                if (pass_reg)
                    state_next = ST_SQUARE;
                else if (status.train_go)
                    state_next = ST_UPD_BIAS;
                else
                    state_next = ST_FINISH;
            end
            ST_UPD_BIAS:
            begin
                cmd.mul_sel = MUL_ERR_FA;
                cmd.upd_sel = UPD_BIAS;
                state_next  = ST_UPD_A;
            end
            ST_UPD_A:
            begin
                cmd.mul_sel = MUL_ERR_FB;
                cmd.upd_sel = UPD_WA;
                state_next  = ST_UPD_B;
            end
            ST_UPD_B:
            begin
                cmd.upd_sel = UPD_WB;
                pass_next   = 1'b1;
                state_next  = ST_MUL_A;
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_COST;
            end
            ST_COST:
            begin
                cmd.cost   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/sgdlr_dp.sv
// ----------------------------------------------------------------------------
// sgdlr_dp
// Datapath: config registers, weights, shared multiplier, updater, cost unit.
// ----------------------------------------------------------------------------
module sgdlr_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [sgdlr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [sgdlr_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [sgdlr_pkg::OP_W-1:0]              op,
    input  logic signed [sgdlr_pkg::FEATURE_W-1:0]  feature_a,
    input  logic signed [sgdlr_pkg::FEATURE_W-1:0]  feature_b,
    input  logic signed [sgdlr_pkg::TARGET_W-1:0]   target,
    output logic signed [sgdlr_pkg::TARGET_W-1:0]   prediction,
    output logic [sgdlr_pkg::COST_W-1:0]            cost,
    output logic                                    converged,
    input  sgdlr_pkg::dp_cmd_t                      cmd,
    output sgdlr_pkg::dp_status_t                   status
);
    import sgdlr_pkg::*;

    localparam int WW = WEIGHT_WIDTH;

    // configuration
    logic [SHIFT_W-1:0] learn_shift_reg;
    logic [COST_W-1:0]  cost_thr_reg;
    logic [INIT_W-1:0]  bias_init_reg, wa_init_reg, wb_init_reg;

    // model state
    logic signed [WW-1:0] bias_reg, wa_reg, wb_reg;
    logic                 done_reg;

    // per-item working registers
    logic [OP_W-1:0]             op_reg;
    logic signed [FEATURE_W-1:0] fa_reg, fb_reg;
    logic [TARGET_W-1:0]         tgt_reg;
    logic signed [PROD_W-1:0]    prod_reg, pa_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic [ERR_W-1:0]            err_reg;
    logic [SQ_W-1:0]             sq_reg;
    logic [TARGET_W-1:0]         pred_res_reg;
    logic [COST_W-1:0]           cost_res_reg;

    // result registers
    logic [TARGET_W-1:0] out_pred_reg;
    logic [COST_W-1:0]   out_cost_reg;
    logic                out_conv_reg;

    logic signed [WW-1:0]        mul_a;
    logic signed [FEATURE_W-1:0] mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [WW-1:0]        err_w;

    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_sh;
    logic [TARGET_W-1:0]     pred_sat;
    logic [ERR_W-1:0]        err_next;

    logic signed [WW-1:0]      upd_w;
    logic signed [PROD_W-1:0]  delta0;
    logic signed [DELTA_W-1:0] delta1, delta2;
    logic signed [DELTA_W:0]   upd_sum;
    logic signed [WW-1:0]      upd_sat;

    logic [ERR_W-1:0]    err_abs;
    logic [TARGET_W-1:0] mag;
    logic [SQ_W-1:0]     sq_next;
    logic [COST_W-1:0]   cost_next;

    assign status.is_init  = (op_reg == OP_INIT);
    assign status.train_go = (op_reg == OP_TRAIN) && !done_reg;

    assign prediction = out_pred_reg;
    assign cost       = out_cost_reg;
    assign converged  = out_conv_reg;

    // shared multiplier
    assign err_w = {{(WW-ERR_W){err_reg[ERR_W-1]}}, err_reg};

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_WA_FA:  begin mul_a = wa_reg; mul_b = fa_reg; end
            MUL_WB_FB:  begin mul_a = wb_reg; mul_b = fb_reg; end
            MUL_ERR_FA: begin mul_a = err_w;  mul_b = fa_reg; end
            MUL_ERR_FB: begin mul_a = err_w;  mul_b = fb_reg; end
            default:    begin mul_a = wa_reg; mul_b = fa_reg; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // prediction: sum, floor shift by 16, saturate to 32 bits
    assign sum_next = {{(SUM_W-WW){bias_reg[WW-1]}}, bias_reg}
                    + {{(SUM_W-PROD_W){pa_reg[PROD_W-1]}}, pa_reg}
                    + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign sum_sh   = sum_reg >>> 16;

    always_comb
    begin
        if ((&sum_sh[SUM_W-1:TARGET_W-1]) | ~(|sum_sh[SUM_W-1:TARGET_W-1]))
            pred_sat = sum_sh[TARGET_W-1:0];
        else if (sum_sh[SUM_W-1])
            pred_sat = {1'b1, {(TARGET_W-1){1'b0}}};
        else
            pred_sat = {1'b0, {(TARGET_W-1){1'b1}}};
    end

    assign err_next = {tgt_reg[TARGET_W-1], tgt_reg} - {pred_sat[TARGET_W-1], pred_sat};

    // weight update: (delta << 16) >>> learn_shift, add, saturate
    always_comb
    begin
        case (cmd.upd_sel)
            UPD_BIAS: upd_w = bias_reg;
            UPD_WA:   upd_w = wa_reg;
            UPD_WB:   upd_w = wb_reg;
            default:  upd_w = bias_reg;
        endcase
    end

    assign delta0  = (cmd.upd_sel == UPD_BIAS)
                   ? {{(PROD_W-ERR_W){err_reg[ERR_W-1]}}, err_reg} : prod_reg;
    assign delta1  = {delta0, 16'b0};
    assign delta2  = delta1 >>> learn_shift_reg;
    assign upd_sum = {delta2[DELTA_W-1], delta2}
                   + {{(DELTA_W+1-WW){upd_w[WW-1]}}, upd_w};

    always_comb
    begin
        if ((&upd_sum[DELTA_W:WW-1]) | ~(|upd_sum[DELTA_W:WW-1]))
            upd_sat = upd_sum[WW-1:0];
        else if (upd_sum[DELTA_W])
            upd_sat = {1'b1, {(WW-1){1'b0}}};
        else
            upd_sat = {1'b0, {(WW-1){1'b1}}};
    end

    // cost: |err|^2 >> 17, saturate to 32 bits
    assign err_abs   = err_reg[ERR_W-1] ? (ERR_W'(0) - err_reg) : err_reg;
    assign mag       = err_abs[TARGET_W-1:0];
    assign sq_next   = mag * mag;
    assign cost_next = (|sq_reg[SQ_W-1:COST_W+17]) ? {COST_W{1'b1}}
                                                    : sq_reg[COST_W+16:17];

    // configuration and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_shift_reg <= LEARN_SHIFT_RST;
            cost_thr_reg    <= COST_THRESHOLD_RST;
            bias_init_reg   <= BIAS_INIT_RST;
            wa_init_reg     <= WEIGHT_A_INIT_RST;
            wb_init_reg     <= WEIGHT_B_INIT_RST;
            bias_reg        <= sat_init(BIAS_INIT_RST);
            wa_reg          <= sat_init(WEIGHT_A_INIT_RST);
            wb_reg          <= sat_init(WEIGHT_B_INIT_RST);
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_LEARN_SHIFT:    learn_shift_reg <= cfg_data[SHIFT_W-1:0];
                    CFG_COST_THRESHOLD: cost_thr_reg    <= cfg_data[COST_W-1:0];
                    CFG_BIAS_INIT:      bias_init_reg   <= cfg_data[INIT_W-1:0];
                    CFG_WEIGHT_A_INIT:  wa_init_reg     <= cfg_data[INIT_W-1:0];
                    CFG_WEIGHT_B_INIT:  wb_init_reg     <= cfg_data[INIT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.init)
            begin
                bias_reg <= sat_init(bias_init_reg);
                wa_reg   <= sat_init(wa_init_reg);
                wb_reg   <= sat_init(wb_init_reg);
                done_reg <= 1'b0;
            end
            case (cmd.upd_sel)
                UPD_BIAS: bias_reg <= upd_sat;
                UPD_WA:   wa_reg   <= upd_sat;
                UPD_WB:   wb_reg   <= upd_sat;
                default: ;
            endcase
            if (cmd.cost && (cost_next <= cost_thr_reg))
                done_reg <= 1'b1;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= op;
            fa_reg       <= feature_a;
            fb_reg       <= feature_b;
            tgt_reg      <= target;
            pred_res_reg <= '0;
            cost_res_reg <= '0;
        end
        prod_reg <= mul_p;
        if (cmd.cap_pa)
            pa_reg <= prod_reg;
        if (cmd.sum)
            sum_reg <= sum_next;
        if (cmd.pred)
        begin
            err_reg <= err_next;
            if (cmd.pred_first)
                pred_res_reg <= pred_sat;
        end
        if (cmd.square)
            sq_reg <= sq_next;
        if (cmd.cost)
            cost_res_reg <= cost_next;
        if (cmd.result)
        begin
            out_pred_reg <= pred_res_reg;
            out_cost_reg <= cost_res_reg;
            out_conv_reg <= done_reg;
        end
    end

endmodule

### tb/sgd_linear_regression_trainer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sgd_linear_regression_trainer_tb
// Self-checking bench for the online LMS trainer. A clocked driver offers
// requests from a queue that the stimulus block fills. A clocked monitor
// checks every result against a cycle-free model of bias, weights and the
// sticky converged flag. Directed corner cases come first, then random
// training episodes and noise over several register settings and idling
// mixes, then a long result hold-off.
// ----------------------------------------------------------------------------
module sgd_linear_regression_trainer_tb;
    import sgdlr_pkg::*;

    // Spare codes: op three behaves as predict, indexes past the list are dropped
    localparam logic [OP_W-1:0]        OP_SPARE         = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = CFG_WEIGHT_B_INIT + 3'd1;

    localparam logic [INIT_W-1:0]          INIT_TOP    = 48'h7FFF_FFFF_FFFF;
    localparam logic [INIT_W-1:0]          INIT_BOTTOM = 48'h8000_0000_0000;
    localparam logic signed [FEATURE_W-1:0] FEAT_TOP    = 16'sh7FFF;
    localparam logic signed [FEATURE_W-1:0] FEAT_BOTTOM = 16'sh8000;
    localparam logic signed [TARGET_W-1:0]  TGT_TOP     = 32'sh7FFF_FFFF;
    localparam logic signed [TARGET_W-1:0]  TGT_BOTTOM  = 32'sh8000_0000;

    // Saturation bounds, held at full model width
    localparam logic signed [127:0] Q16_TOP    = 128'sd2147483647;
    localparam logic signed [127:0] Q16_BOTTOM = -Q16_TOP - 128'sd1;
    localparam logic signed [127:0] W_TOP      = (128'sd1 <<< (WEIGHT_WIDTH - 1)) - 128'sd1;
    localparam logic signed [127:0] W_BOTTOM   = -W_TOP - 128'sd1;

    localparam int unsigned HOLD_LEN    = 300;      // receiver hold-off, cycles
    localparam int unsigned SETTLE_GAP  = 4;        // quiet cycles before a register write
    localparam int unsigned DRAIN_TAIL  = 40;       // extra wait after the last result is back
    localparam int unsigned PHASE_ITEMS = 190;
    localparam int unsigned TIMEOUT_NS  = 5_000_000;

    typedef struct packed {
        logic [OP_W-1:0]             op;
        logic signed [FEATURE_W-1:0] fa;
        logic signed [FEATURE_W-1:0] fb;
        logic signed [TARGET_W-1:0]  target;
    } sample_t;

    typedef struct packed {
        logic signed [TARGET_W-1:0] prediction;
        logic [COST_W-1:0]          cost;
        logic                       converged;
    } trainer_out_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_write;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    sgdlr_req_if req_bus ();
    sgdlr_rsp_if rsp_bus ();

    sgd_linear_regression_trainer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Requests waiting to be offered, and results the block still owes
    sample_t      queued_samples[$];
    trainer_out_t due_results[$];
    int unsigned  samples_queued = 0;
    int unsigned  fault_count = 0;

    // Idling mix, changed only between phases
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // Long hold-off of the result side
    logic        hold_go;
    int unsigned hold_cycles;
    logic        rx_hold;

    // Model copy of the trainer state and its registers
    logic [SHIFT_W-1:0]             cfg_shift;
    logic [COST_W-1:0]              cfg_thresh;
    logic signed [WEIGHT_WIDTH-1:0] cfg_bias0, cfg_a0, cfg_b0;
    logic signed [WEIGHT_WIDTH-1:0] w_bias, w_a, w_b;
    logic                           frozen;

    // ------------------------------------------------------------------------
    // Clock: 10 ns period
    // ------------------------------------------------------------------------
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model arithmetic. Every sum is carried exactly at 128 bits, then
    // floored and clamped the way the datapath does.
    // ------------------------------------------------------------------------

    // bias + wa*fa + wb*fb in Q.32, floored to Q16.16, saturated to 32 bits
    function automatic logic signed [TARGET_W-1:0] linear_forecast(
        input logic signed [WEIGHT_WIDTH-1:0] b,
        input logic signed [WEIGHT_WIDTH-1:0] wa,
        input logic signed [WEIGHT_WIDTH-1:0] wb,
        input logic signed [FEATURE_W-1:0]    fa,
        input logic signed [FEATURE_W-1:0]    fb
    );
        logic signed [127:0] xb, xwa, xwb, xfa, xfb, acc;
        xb  = b;
        xwa = wa;
        xwb = wb;
        xfa = fa;
        xfb = fb;
        acc = (xb + xwa * xfa + xwb * xfb) >>> 16;
        if (acc > Q16_TOP)
            acc = Q16_TOP;
        else if (acc < Q16_BOTTOM)
            acc = Q16_BOTTOM;
        return acc[TARGET_W-1:0];
    endfunction

    // weight + ((err * feat) << 16) >>> shift, saturated to the weight range
    function automatic logic signed [WEIGHT_WIDTH-1:0] lms_nudge(
        input logic signed [WEIGHT_WIDTH-1:0] w,
        input logic signed [63:0]             err,
        input logic signed [FEATURE_W-1:0]    feat,
        input logic [SHIFT_W-1:0]             sh
    );
        logic signed [127:0] step, xw, xe, xf, acc;
        xw   = w;
        xe   = err;
        xf   = feat;
        step = (xe * xf) <<< 16;
        step = step >>> sh;
        acc  = xw + step;
        if (acc > W_TOP)
            acc = W_TOP;
        else if (acc < W_BOTTOM)
            acc = W_BOTTOM;
        return acc[WEIGHT_WIDTH-1:0];
    endfunction

    // Advance the model by one request and produce the result it owes
    task automatic train_step(input sample_t s, output trainer_out_t o);
        logic signed [TARGET_W-1:0] guess;
        logic signed [63:0]         miss, miss2;
        logic [63:0]                mag, sq;
        o = '0;
        if (s.op == OP_INIT)
        begin
            w_bias = cfg_bias0;
            w_a    = cfg_a0;
            w_b    = cfg_b0;
            frozen = 1'b0;
        end
        else
        begin
            // Predict, spare op and frozen train all report the prediction only
            guess        = linear_forecast(w_bias, w_a, w_b, s.fa, s.fb);
            o.prediction = guess;
            if (s.op == OP_TRAIN && !frozen)
            begin
                miss   = s.target;
                miss   = miss - guess;
                w_bias = lms_nudge(w_bias, miss, 16'sd1, cfg_shift);
                w_a    = lms_nudge(w_a, miss, s.fa, cfg_shift);
                w_b    = lms_nudge(w_b, miss, s.fb, cfg_shift);
                // Cost comes from a second prediction with the updated weights
                miss2  = s.target;
                miss2  = miss2 - linear_forecast(w_bias, w_a, w_b, s.fa, s.fb);
                mag    = (miss2 < 0) ? -miss2 : miss2;
                sq     = (mag * mag) >> 17;
                if (sq > 64'hFFFF_FFFF)
                    sq = 64'hFFFF_FFFF;
                o.cost = sq[COST_W-1:0];
                if (o.cost <= cfg_thresh)
                    frozen = 1'b1;
            end
        end
        o.converged = frozen;
    endtask

    // ------------------------------------------------------------------------
    // Request driver: record the model's answer for each accepted request,
    // then either hold the current offer, advance to the next queued one,
    // or idle with junk payload.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        sample_t      nxt;
        sample_t      seen;
        trainer_out_t owed;
        if (!rst_n)
        begin
            req_bus.valid     <= 1'b0;
            req_bus.op        <= OP_INIT;
            req_bus.feature_a <= '0;
            req_bus.feature_b <= '0;
            req_bus.target    <= '0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                seen.op     = req_bus.op;
                seen.fa     = req_bus.feature_a;
                seen.fb     = req_bus.feature_b;
                seen.target = req_bus.target;
                train_step(seen, owed);
                due_results.push_back(owed);
            end
            // Hold the payload while an offer is stalled
            if (!req_bus.valid || req_bus.ready)
            begin
                if (queued_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = queued_samples.pop_front();
                    req_bus.valid     <= 1'b1;
                    req_bus.op        <= nxt.op;
                    req_bus.feature_a <= nxt.fa;
                    req_bus.feature_b <= nxt.fb;
                    req_bus.target    <= nxt.target;
                end
                else
                begin
                    req_bus.valid     <= 1'b0;
                    req_bus.op        <= OP_W'($urandom);
                    req_bus.feature_a <= FEATURE_W'($urandom);
                    req_bus.feature_b <= FEATURE_W'($urandom);
                    req_bus.target    <= $urandom;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest one owed,
    // and toss ready according to the stall mix or the hold-off.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_results
        trainer_out_t got;
        trainer_out_t want;
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got.prediction = rsp_bus.prediction;
                got.cost       = rsp_bus.cost;
                got.converged  = rsp_bus.converged;
                if (due_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: result with no request outstanding: pred %0d cost %0d conv %0b",
                                 $time, got.prediction, got.cost, got.converged);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.prediction !== want.prediction || got.cost !== want.cost ||
                        got.converged !== want.converged)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("%0t: mismatch pred %0d/%0d cost %0d/%0d conv %0b/%0b (exp/act)",
                                     $time, want.prediction, got.prediction, want.cost, got.cost,
                                     want.converged, got.converged);
                    end
                end
            end
            rsp_bus.ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Count out the hold-off once it is armed; the sender keeps offering
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cycles <= 0;
        else if (hold_go && hold_cycles < HOLD_LEN)
            hold_cycles <= hold_cycles + 1;
    end

    assign rx_hold = hold_go && (hold_cycles < HOLD_LEN);

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_sample(
        input logic [OP_W-1:0]             op,
        input logic signed [FEATURE_W-1:0] fa,
        input logic signed [FEATURE_W-1:0] fb,
        input logic signed [TARGET_W-1:0]  t
    );
        queued_samples.push_back(sample_t'{op, fa, fb, t});
        samples_queued++;
    endtask

    // Wait until every request is taken and every result is back
    task automatic wait_drained();
        @(negedge clk);
        while (queued_samples.size() != 0 || due_results.size() != 0 || req_bus.valid)
            @(negedge clk);
        repeat (SETTLE_GAP) @(negedge clk);
    endtask

    // One register write; the strobe is left high for the caller to drop
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        case (idx)
            CFG_LEARN_SHIFT:    cfg_shift  = d[SHIFT_W-1:0];
            CFG_COST_THRESHOLD: cfg_thresh = d[COST_W-1:0];
            CFG_BIAS_INIT:      cfg_bias0  = d[INIT_W-1:0];
            CFG_WEIGHT_A_INIT:  cfg_a0     = d[INIT_W-1:0];
            CFG_WEIGHT_B_INIT:  cfg_b0     = d[INIT_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic program_regs(
        input logic [SHIFT_W-1:0] sh,
        input logic [COST_W-1:0]  th,
        input logic [INIT_W-1:0]  b0,
        input logic [INIT_W-1:0]  a0,
        input logic [INIT_W-1:0]  c0
    );
        write_reg(CFG_LEARN_SHIFT, CFG_DATA_W'(sh));
        write_reg(CFG_COST_THRESHOLD, CFG_DATA_W'(th));
        write_reg(CFG_BIAS_INIT, b0);
        write_reg(CFG_WEIGHT_A_INIT, a0);
        write_reg(CFG_WEIGHT_B_INIT, c0);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Random settings: small weights and a workable rate, or anything at all
    task automatic configure_random(input bit any_value);
        logic [SHIFT_W-1:0] sh;
        logic [COST_W-1:0]  th;
        logic [INIT_W-1:0]  v[3];
        longint             x;
        int                 k;
        sh = any_value ? SHIFT_W'($urandom_range(0, 63)) : SHIFT_W'($urandom_range(3, 10));
        case ($urandom_range(0, 4))
            0:       th = '0;
            1:       th = COST_THRESHOLD_RST;
            2:       th = $urandom;
            3:       th = 32'hFFFF_FFFF;
            default: th = $urandom_range(0, 1 << 20);
        endcase
        for (k = 0; k < 3; k++)
        begin
            if (any_value)
                v[k] = INIT_W'({$urandom, $urandom});
            else
            begin
                // About +-2.0 in Q16.32
                x    = (longint'($urandom) - 64'sd2147483648) * 4;
                v[k] = x[INIT_W-1:0];
            end
        end
        program_regs(sh, th, v[0], v[1], v[2]);
    endtask

    task automatic set_idling(input int unsigned s, input int unsigned r);
        @(posedge clk);
        send_idle_pct  <= s;
        recv_stall_pct <= r;
    endtask

    // Init, then trains on samples from a hidden linear model so the
    // weights move toward it and the flag can set; a few predicts between.
    task automatic queue_episode();
        longint span, b0, a0, c0, fa, fb, t;
        int     n, len;
        // Keep rate * feature^2 near one so the updates stay stable
        span = (longint'(1) << (cfg_shift / 2)) - 1;
        if (span < 1)
            span = 1;
        if (span > 32767)
            span = 32767;
        b0  = longint'($urandom_range(0, 8 * 65536)) - 4 * 65536;
        a0  = longint'($urandom_range(0, 8 * 65536)) - 4 * 65536;
        c0  = longint'($urandom_range(0, 8 * 65536)) - 4 * 65536;
        len = $urandom_range(5, 25);
        queue_sample(OP_INIT, FEATURE_W'($urandom), FEATURE_W'($urandom), $urandom);
        for (n = 0; n < len; n++)
        begin
            fa = longint'($urandom_range(0, 2 * span)) - span;
            fb = longint'($urandom_range(0, 2 * span)) - span;
            t  = b0 + a0 * fa + c0 * fb;
            if ($urandom_range(0, 3) == 0)
                t = t + longint'($urandom_range(0, 4000)) - 2000;
            if (t > 64'sd2147483647)
                t = 64'sd2147483647;
            if (t < -64'sd2147483648)
                t = -64'sd2147483648;
            queue_sample(OP_TRAIN, fa[FEATURE_W-1:0], fb[FEATURE_W-1:0], t[TARGET_W-1:0]);
            if ($urandom_range(0, 7) == 0)
                queue_sample(OP_PREDICT, fa[FEATURE_W-1:0], fb[FEATURE_W-1:0], $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned send_mix[6];
        int unsigned recv_mix[6];
        int unsigned phase;
        int unsigned quota;
        int          n;

        send_mix = '{0, 74, 0, 15, 15, 0};
        recv_mix = '{0, 0, 74, 15, 15, 0};

        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        req_bus.valid     = 1'b0;
        req_bus.op        = OP_INIT;
        req_bus.feature_a = '0;
        req_bus.feature_b = '0;
        req_bus.target    = '0;
        rsp_bus.ready     = 1'b0;
        hold_go           = 1'b0;

        // Model state after reset
        cfg_shift  = LEARN_SHIFT_RST;
        cfg_thresh = COST_THRESHOLD_RST;
        cfg_bias0  = BIAS_INIT_RST;
        cfg_a0     = WEIGHT_A_INIT_RST;
        cfg_b0     = WEIGHT_B_INIT_RST;
        w_bias     = BIAS_INIT_RST;
        w_a        = WEIGHT_A_INIT_RST;
        w_b        = WEIGHT_B_INIT_RST;
        frozen     = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset weights and registers, untouched
        @(negedge clk);
        queue_sample(OP_PREDICT, 16'sd0, 16'sd0, 32'sd0);
        queue_sample(OP_PREDICT, FEAT_TOP, FEAT_BOTTOM, TGT_TOP);
        queue_sample(OP_TRAIN, 16'sd1, 16'sd1, 32'sh0001_0000);
        queue_sample(OP_SPARE, FEAT_BOTTOM, FEAT_TOP, -32'sd1);
        queue_sample(OP_INIT, FEAT_TOP, FEAT_TOP, TGT_BOTTOM);
        wait_drained();

        // Full rate, zero threshold, extreme weights: prediction and
        // weight saturation both ways, widest error
        program_regs('0, '0, INIT_TOP, INIT_BOTTOM, INIT_TOP);
        @(negedge clk);
        queue_sample(OP_INIT, 16'sd0, 16'sd0, 32'sd0);
        queue_sample(OP_PREDICT, FEAT_TOP, FEAT_TOP, 32'sd0);
        queue_sample(OP_PREDICT, FEAT_BOTTOM, FEAT_TOP, 32'sd0);
        queue_sample(OP_PREDICT, FEAT_TOP, FEAT_BOTTOM, 32'sd0);
        queue_sample(OP_TRAIN, FEAT_BOTTOM, FEAT_BOTTOM, TGT_BOTTOM);
        queue_sample(OP_TRAIN, FEAT_TOP, FEAT_TOP, TGT_TOP);
        queue_sample(OP_TRAIN, FEAT_TOP, FEAT_BOTTOM, TGT_TOP);
        queue_sample(OP_PREDICT, 16'sd0, 16'sd0, 32'sd0);
        queue_sample(OP_SPARE, -16'sd1, 16'sd1, TGT_TOP);
        wait_drained();

        // Slowest rate, top threshold: first train freezes, later trains
        // only report; init clears the flag. Also drop an unused index.
        program_regs(6'd63, 32'hFFFF_FFFF, INIT_BOTTOM, INIT_TOP, INIT_BOTTOM);
        write_reg(CFG_FIRST_UNUSED + CFG_INDEX_W'($urandom_range(0, 2)),
                  CFG_DATA_W'({$urandom, $urandom}));
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        queue_sample(OP_INIT, 16'sd0, 16'sd0, 32'sd0);
        queue_sample(OP_TRAIN, 16'sd3, -16'sd5, 32'sh0002_0000);
        queue_sample(OP_TRAIN, -16'sd7, 16'sd2, TGT_BOTTOM);
        queue_sample(OP_PREDICT, 16'sd1, 16'sd1, 32'sd0);
        queue_sample(OP_SPARE, 16'sd1, 16'sd1, 32'sd0);
        queue_sample(OP_INIT, 16'sd0, 16'sd0, 32'sd0);
        queue_sample(OP_TRAIN, -16'sd1, 16'sd1, TGT_TOP);

        // Random phases, one idling mix each; mostly episodes, some noise
        for (phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            configure_random(phase == 4);
            set_idling(send_mix[phase], recv_mix[phase]);
            quota = samples_queued + PHASE_ITEMS;
            @(negedge clk);
            while (samples_queued < quota)
            begin
                if ($urandom_range(0, 99) < 80)
                    queue_episode();
                else
                begin
                    for (n = $urandom_range(1, 4); n > 0; n--)
                        queue_sample(OP_W'($urandom_range(0, 3)), FEATURE_W'($urandom),
                                     FEATURE_W'($urandom), $urandom);
                end
            end
        end

        // Hold results off while requests keep coming: the block fills
        // and must stall its input
        wait_drained();
        configure_random(1'b0);
        set_idling(0, 0);
        @(posedge clk);
        hold_go <= 1'b1;
        @(negedge clk);
        queue_episode();
        queue_episode();

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (fault_count == 0 && due_results.size() == 0)
            $display("sgd_linear_regression_trainer_tb: done, clean");
        else
            $display("sgd_linear_regression_trainer_tb: done, errors");
        $finish;
    end

    // Give up if the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("sgd_linear_regression_trainer_tb: done, errors");
        $finish;
    end

endmodule
